// ----- rtl/core/pulse_burst_counter_and_pulse_train_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef PULSE_BURST_COUNTER_AND_PULSE_TRAIN_DEFINES_SVH
`define PULSE_BURST_COUNTER_AND_PULSE_TRAIN_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pbc_pkg.sv -----
`timescale 1ns / 1ps

package pbc_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_QUEUE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_LIMIT     = 3'd2,
    REG_PULSE_LOW = 3'd3,
    REG_PAUSE     = 3'd4
  } reg_idx_t;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [7:0]  LIMIT_RST     = 8'd250;
  localparam logic [15:0] PULSE_LOW_RST = 16'd50;
  localparam logic [15:0] PAUSE_RST     = 16'd50;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] burst_timeout_ms;
    logic [7:0]  burst_limit;
    logic [15:0] pulse_low_ms;
    logic [15:0] pulse_pause_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  credit_add;
    logic        output_level;
    logic [15:0] pending_pulses;
    logic [7:0]  burst_count;
  } result_t;

endpackage

// ----- rtl/core/pbc_regs.sv -----
`timescale 1ns / 1ps

module pbc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output pbc_pkg::cfg_t              cfg
);

  logic                 wr_en;
  pbc_pkg::reg_idx_t    idx;

  assign idx   = pbc_pkg::reg_idx_t'(paddr[pbc_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= pbc_pkg::DEBOUNCE_RST;
      cfg.burst_timeout_ms <= pbc_pkg::TIMEOUT_RST;
      cfg.burst_limit      <= pbc_pkg::LIMIT_RST;
      cfg.pulse_low_ms     <= pbc_pkg::PULSE_LOW_RST;
      cfg.pulse_pause_ms   <= pbc_pkg::PAUSE_RST;
    end else if (wr_en) begin
      case (idx)
        pbc_pkg::REG_DEBOUNCE:  cfg.debounce_ms      <= pwdata[15:0];
        pbc_pkg::REG_TIMEOUT:   cfg.burst_timeout_ms <= pwdata[15:0];
        pbc_pkg::REG_LIMIT:     cfg.burst_limit      <= pwdata[7:0];
        pbc_pkg::REG_PULSE_LOW: cfg.pulse_low_ms     <= pwdata[15:0];
        pbc_pkg::REG_PAUSE:     cfg.pulse_pause_ms   <= pwdata[15:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    case (idx)
      pbc_pkg::REG_DEBOUNCE:  prdata = {16'd0, cfg.debounce_ms};
      pbc_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.burst_timeout_ms};
      pbc_pkg::REG_LIMIT:     prdata = {24'd0, cfg.burst_limit};
      pbc_pkg::REG_PULSE_LOW: prdata = {16'd0, cfg.pulse_low_ms};
      pbc_pkg::REG_PAUSE:     prdata = {16'd0, cfg.pulse_pause_ms};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/pbc_core.sv -----
`timescale 1ns / 1ps

module pbc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pbc_pkg::func_t   func,
  input  logic             startup_done,
  input  logic [15:0]      pulse_count,
  input  pbc_pkg::cfg_t    cfg,
  output pbc_pkg::result_t result
);

  logic [31:0] now_ms, now_ms_next;
  logic [31:0] last_edge_ms, last_edge_ms_next;
  logic [31:0] burst_end_ms, burst_end_ms_next;
  logic [7:0]  burst_edges, burst_edges_next;
  logic [15:0] queued_pulses, queued_pulses_next;
  logic        train_active, train_active_next;
  logic        in_pause, in_pause_next;
  logic [31:0] phase_start_ms, phase_start_ms_next;
  logic        level, level_next;

  logic [31:0] now_inc;
  logic [31:0] quiet_ms;
  logic [31:0] phase_elapsed;
  logic [31:0] since_edge;
  logic [16:0] queue_sum;
  logic [7:0]  credit;

  assign now_inc       = now_ms + 32'd1;
  assign quiet_ms      = now_inc - burst_end_ms;
  assign phase_elapsed = now_inc - phase_start_ms;
  assign since_edge    = now_ms - last_edge_ms;
  assign queue_sum     = {1'b0, queued_pulses} + {1'b0, pulse_count};

  always_comb begin
    now_ms_next         = now_ms;
    last_edge_ms_next   = last_edge_ms;
    burst_end_ms_next   = burst_end_ms;
    burst_edges_next    = burst_edges;
    queued_pulses_next  = queued_pulses;
    train_active_next   = train_active;
    in_pause_next       = in_pause;
    phase_start_ms_next = phase_start_ms;
    level_next          = level;
    credit              = 8'd0;

    case (func)
      pbc_pkg::FUNC_TICK: begin
        now_ms_next = now_inc;
        if (burst_edges != 8'd0 && quiet_ms > {16'd0, cfg.burst_timeout_ms}) begin
          credit           = burst_edges;
          burst_edges_next = 8'd0;
        end
        if (queued_pulses != 16'd0) begin
          if (!train_active) begin
            train_active_next   = 1'b1;
            in_pause_next       = 1'b0;
            level_next          = 1'b0;
            phase_start_ms_next = now_inc;
          end else if (!in_pause && phase_elapsed >= {16'd0, cfg.pulse_low_ms}) begin
            in_pause_next       = 1'b1;
            level_next          = 1'b1;
            phase_start_ms_next = now_inc;
          end else if (in_pause && phase_elapsed >= {16'd0, cfg.pulse_pause_ms}) begin
            queued_pulses_next = queued_pulses - 16'd1;
            in_pause_next      = 1'b0;
            level_next         = 1'b0;
            if (queued_pulses != 16'd1) begin
              phase_start_ms_next = now_inc;
            end else begin
              train_active_next = 1'b0;
            end
          end
        end else if (train_active) begin
          train_active_next = 1'b0;
          in_pause_next     = 1'b0;
          level_next        = 1'b0;
        end
      end
      pbc_pkg::FUNC_EDGE: begin
        if (startup_done && since_edge >= {16'd0, cfg.debounce_ms}) begin
          last_edge_ms_next = now_ms;
          burst_end_ms_next = now_ms;
          if (burst_edges < cfg.burst_limit) begin
            burst_edges_next = burst_edges + 8'd1;
          end
        end
      end
      pbc_pkg::FUNC_QUEUE: begin
        if (pulse_count != 16'd0) begin
          queued_pulses_next = queue_sum[16] ? 16'hFFFF : queue_sum[15:0];
        end
      end
      default: ;  // no-op item
    endcase
  end

  assign result.credit_add     = credit;
  assign result.output_level   = level_next;
  assign result.pending_pulses = queued_pulses_next;
  assign result.burst_count    = burst_edges_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= 32'd0;
      last_edge_ms   <= 32'd0;
      burst_end_ms   <= 32'd0;
      burst_edges    <= 8'd0;
      queued_pulses  <= 16'd0;
      train_active   <= 1'b0;
      in_pause       <= 1'b0;
      phase_start_ms <= 32'd0;
      level          <= 1'b0;
    end else if (fire) begin
      now_ms         <= now_ms_next;
      last_edge_ms   <= last_edge_ms_next;
      burst_end_ms   <= burst_end_ms_next;
      burst_edges    <= burst_edges_next;
      queued_pulses  <= queued_pulses_next;
      train_active   <= train_active_next;
      in_pause       <= in_pause_next;
      phase_start_ms <= phase_start_ms_next;
      level          <= level_next;
    end
  end

endmodule

// ----- rtl/core/pulse_burst_counter_and_pulse_train.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | func, startup_done, pulse_count
// out      | out_valid / out_ready | credit_add, output_level, pending_pulses,
//          |                       | burst_count
// cfg      | APB psel/penable      | paddr, pwdata, prdata, pready
//
// One item per cycle sustained while out_ready stays high. The input register
// takes the item at the accepting edge and the state update writes the result
// register once the result register can advance, which a stalled output
// delays; out_valid rises when the result register is written.
// The per-item throughput is set by the single state-update stage in pbc_core.
// Synchronous active-high reset clears the valid flags, block state and
// registers to defaults.
// A stalled output holds the result register; the input register then fills
// and in_ready drops until out_ready returns.

`include "pulse_burst_counter_and_pulse_train_defines.svh"

module pulse_burst_counter_and_pulse_train (
  input  logic                       clk,
  input  logic                       rst,
  // item input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic                       startup_done,
  input  logic [15:0]                pulse_count,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 credit_add,
  output logic                       output_level,
  output logic [15:0]                pending_pulses,
  output logic [7:0]                 burst_count,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Input register stage
  logic                stage_valid;
  pbc_pkg::func_t      stage_func;
  logic                stage_startup;
  logic [15:0]         stage_count;

  logic                advance;   // result register can take a new item
  logic                fire;      // staged item is processed this cycle
  pbc_pkg::cfg_t       cfg;
  pbc_pkg::result_t    result;

  assign pready   = 1'b1;
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;
  assign fire     = stage_valid && advance;

  pbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pbc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .func         (stage_func),
    .startup_done (stage_startup),
    .pulse_count  (stage_count),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_func    <= pbc_pkg::func_t'(func);
      stage_startup <= startup_done;
      stage_count   <= pulse_count;
    end
  end

  // Result register: loads when the staged item is processed, holds on stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      credit_add     <= result.credit_add;
      output_level   <= result.output_level;
      pending_pulses <= result.pending_pulses;
      burst_count    <= result.burst_count;
    end
  end

  // A finished burst is always cleared in the same item.
  `PBC_ASSERT_NOW(a_credit_clears_burst, clk, rst, out_valid && credit_add != 8'd0, burst_count == 8'd0, "credit handed out but burst not cleared")
  // The output is high only during a pause, which needs a queued pulse.
  `PBC_ASSERT_NOW(a_high_needs_queue, clk, rst, out_valid && output_level, pending_pulses != 16'd0, "output high with empty queue")
  // Input back-pressure only comes from a stalled, full result register.
  `PBC_ASSERT_NOW(a_ready_low_cause, clk, rst, !in_ready, stage_valid && out_valid && !out_ready, "in_ready low without a stall")
  // An accepted item is always staged on the next cycle.
  `PBC_ASSERT_NEXT(a_accept_staged, clk, rst, in_valid && in_ready, stage_valid, "accepted item not staged")

endmodule

// ----- verif/pbc_result_check.sv -----
`timescale 1ns / 1ps

module pbc_result_check
  import pbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          func,
  input  logic                startup_done,
  input  logic [15:0]         pulse_count,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [7:0]          credit_add,
  input  logic                output_level,
  input  logic [15:0]         pending_pulses,
  input  logic [7:0]          burst_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output int                  mismatches,
  output int                  awaited,
  output int                  readouts,
  output int                  credited
);

  // register copy and block state as the block should hold them
  cfg_t        cfg;
  logic [31:0] clock_ms;
  logic [31:0] last_edge_at;
  logic [31:0] burst_end_at;
  logic [31:0] phase_began;
  logic [7:0]  edge_tally;
  logic [15:0] pulses_waiting;
  logic        train_on;
  logic        pausing;
  logic        level_q;

  result_t awaited_readouts[$];

  task automatic report(input string msg);
    $display("MISMATCH at readout %0d: %s", readouts, msg);
    mismatches++;
  endtask

  task automatic step_burst_and_train(input func_t f, input logic sd,
                                      input logic [15:0] cnt, output result_t r);
    logic [7:0]  credit;
    logic [31:0] elapsed;
    logic [16:0] total;
    credit = '0;
    case (f)
      FUNC_TICK: begin
        clock_ms = clock_ms + 32'd1;
        // quiet time is measured as a difference, so it survives wrap
        if (edge_tally != 0 &&
            (clock_ms - burst_end_at) > {16'd0, cfg.burst_timeout_ms}) begin
          credit = edge_tally;
          edge_tally = '0;
        end
        elapsed = clock_ms - phase_began;
        if (pulses_waiting != 0) begin
          if (!train_on) begin
            train_on = 1'b1;
            pausing = 1'b0;
            level_q = 1'b0;
            phase_began = clock_ms;
          end else if (!pausing && elapsed >= {16'd0, cfg.pulse_low_ms}) begin
            pausing = 1'b1;
            level_q = 1'b1;
            phase_began = clock_ms;
          end else if (pausing && elapsed >= {16'd0, cfg.pulse_pause_ms}) begin
            pulses_waiting = pulses_waiting - 16'd1;
            pausing = 1'b0;
            level_q = 1'b0;
            if (pulses_waiting != 0) phase_began = clock_ms;
            else train_on = 1'b0;
          end
        end else if (train_on) begin
          train_on = 1'b0;
          pausing = 1'b0;
          level_q = 1'b0;
        end
      end
      FUNC_EDGE: begin
        if (sd && (clock_ms - last_edge_at) >= {16'd0, cfg.debounce_ms}) begin
          last_edge_at = clock_ms;
          if (edge_tally < cfg.burst_limit) edge_tally = edge_tally + 8'd1;
          burst_end_at = clock_ms;
        end
      end
      FUNC_QUEUE: begin
        if (cnt != 0) begin
          total = {1'b0, pulses_waiting} + {1'b0, cnt};
          pulses_waiting = total[16] ? 16'hFFFF : total[15:0];
        end
      end
      default: ;
    endcase
    r.credit_add     = credit;
    r.output_level   = level_q;
    r.pending_pulses = pulses_waiting;
    r.burst_count    = edge_tally;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      cfg = {DEBOUNCE_RST, TIMEOUT_RST, LIMIT_RST, PULSE_LOW_RST, PAUSE_RST};
      clock_ms = '0;
      last_edge_at = '0;
      burst_end_at = '0;
      phase_began = '0;
      edge_tally = '0;
      pulses_waiting = '0;
      train_on = 1'b0;
      pausing = 1'b0;
      level_q = 1'b0;
      awaited_readouts.delete();
      mismatches = 0;
      readouts = 0;
      credited = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_DEBOUNCE:  cfg.debounce_ms      = pwdata[15:0];
          REG_TIMEOUT:   cfg.burst_timeout_ms = pwdata[15:0];
          REG_LIMIT:     cfg.burst_limit      = pwdata[7:0];
          REG_PULSE_LOW: cfg.pulse_low_ms     = pwdata[15:0];
          REG_PAUSE:     cfg.pulse_pause_ms   = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_burst_and_train(func_t'(func), startup_done, pulse_count, want);
        if (want.credit_add != 0) credited++;
        awaited_readouts.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {credit_add, output_level, pending_pulses, burst_count};
        if (awaited_readouts.size() == 0) begin
          report("result arrived with nothing awaited");
        end else begin
          want = awaited_readouts.pop_front();
          if (got.credit_add !== want.credit_add)
            report($sformatf("credit_add %0d, want %0d", got.credit_add, want.credit_add));
          if (got.output_level !== want.output_level)
            report($sformatf("output_level %0d, want %0d",
                             got.output_level, want.output_level));
          if (got.pending_pulses !== want.pending_pulses)
            report($sformatf("pending_pulses %0d, want %0d",
                             got.pending_pulses, want.pending_pulses));
          if (got.burst_count !== want.burst_count)
            report($sformatf("burst_count %0d, want %0d", got.burst_count, want.burst_count));
        end
        readouts++;
      end
    end
    awaited <= awaited_readouts.size();
  end

endmodule

// ----- verif/pulse_burst_counter_and_pulse_train_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the burst counter / pulse train block. The checker
// beside the DUT predicts every result; this module only makes traffic.
module pulse_burst_counter_and_pulse_train_tb;
  import pbc_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int LATENCY        = 2;     // input reg + state update
  localparam int RX_HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int NUM_PHASES     = 6;
  // one past the last register: the block must ignore it
  localparam logic [ADDR_W-1:0] SPARE_REG_ADDR = 5'd20;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_NOP;
  logic        startup_done = 1'b0;
  logic [15:0] pulse_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  credit_add;
  logic        output_level;
  logic [15:0] pending_pulses;
  logic [7:0]  burst_count;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches, awaited, readouts, credited;

  // knobs shared between the sender and receiver processes
  logic tx_steady = 1'b0;    // sender never idles
  logic rx_steady = 1'b0;    // receiver never stalls
  logic rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  logic rx_holding = 1'b0;
  int   sent_items = 0;
  int   settings_applied = 0;
  int   quiet_cycles = 0;
  cfg_t live_cfg = {DEBOUNCE_RST, TIMEOUT_RST, LIMIT_RST, PULSE_LOW_RST, PAUSE_RST};

  pulse_burst_counter_and_pulse_train u_top (
    .clk, .rst,
    .in_valid, .in_ready, .func, .startup_done, .pulse_count,
    .out_valid, .out_ready, .credit_add, .output_level, .pending_pulses, .burst_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pbc_result_check u_check (
    .clk, .rst,
    .in_valid, .in_ready, .func, .startup_done, .pulse_count,
    .out_valid, .out_ready, .credit_add, .output_level, .pending_pulses, .burst_count,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .awaited, .readouts, .credited
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Small counts keep the train draining; zero is the "queue nothing" case.
  function automatic logic [15:0] pulse_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 3));
    if (r < 85) return 16'd0;
    return 16'($urandom_range(4, 30));
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(input reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // Register settings per phase, fields in cfg_t order:
  // debounce, timeout, limit, low, pause.
  function automatic cfg_t phase_setting(input int p);
    case (p)
      0: return {16'd2, 16'd6, 8'd8, 16'd2, 16'd3};
      1: return {16'd0, 16'd1, 8'd255, 16'd0, 16'd0};
      // every register at its top: time runs and pulses queue, nothing else can move
      2: return {16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF};
      3: return {16'd1, 16'd12, 8'd4, 16'd1, 16'd1};
      4: return {16'($urandom_range(0, 4)), 16'($urandom_range(1, 25)),
                 8'($urandom_range(1, 12)), 16'($urandom_range(0, 6)),
                 16'($urandom_range(0, 6))};
      default: return {16'd3, 16'd4, 8'd2, 16'd0, 16'd5};
    endcase
  endfunction

  // Offer one item; valid stays up after acceptance unless the next call
  // idles, so back-to-back items never toggle valid within a time step.
  task automatic send(input func_t f, input logic sd, input logic [15:0] cnt);
    int gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    startup_done <= sd;
    pulse_count  <= cnt;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Stop offering and wait until every predicted result has been seen.
  // The drain waits on the clock first so the checker's count includes the last accepted item.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), val};  // upper bits must be ignored
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain();
    write_reg(reg_addr(REG_DEBOUNCE), c.debounce_ms);
    write_reg(reg_addr(REG_TIMEOUT), c.burst_timeout_ms);
    write_reg(reg_addr(REG_LIMIT), {8'd0, c.burst_limit});
    write_reg(reg_addr(REG_PULSE_LOW), c.pulse_low_ms);
    write_reg(reg_addr(REG_PAUSE), c.pulse_pause_ms);
    live_cfg = c;
    settings_applied++;
  endtask

  // One short well-formed sequence, or a bit of noise.
  task automatic send_chunk();
    int kind;
    int quiet_len;
    kind = $urandom_range(0, 9);
    quiet_len = (live_cfg.burst_timeout_ms > 38) ? 40 : live_cfg.burst_timeout_ms + 2;
    if (kind < 4) begin
      // burst: edges with a few ticks between, sometimes inside debounce
      repeat ($urandom_range(1, 6)) begin
        send(FUNC_EDGE, $urandom_range(0, 15) != 0, 16'($urandom));
        repeat ($urandom_range(0, 3)) send(FUNC_TICK, 1'($urandom), 16'($urandom));
      end
    end else if (kind < 6) begin
      // quiet stretch long enough to close the burst when the timeout is at most 38
      repeat (quiet_len) send(FUNC_TICK, 1'($urandom), 16'($urandom));
    end else if (kind < 8) begin
      send(FUNC_QUEUE, 1'($urandom), pulse_amount());
      repeat ($urandom_range(1, 8)) send(FUNC_TICK, 1'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(1, 4))
        send(func_t'(2'($urandom_range(0, 3))), 1'($urandom), 16'($urandom));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        rx_holding = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end
      stall = rx_steady ? 0 : gap_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: any handshake on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int start;
    int target;
    logic hold_done;
    hold_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset register values ---
    send(FUNC_EDGE, 1'b1, 16'hFFFF);  // early edge: inside debounce of reset
    send(FUNC_NOP, 1'b1, 16'h5A5A);   // no-op shows state, credit 0
    send(FUNC_QUEUE, 1'b1, 16'd0);    // zero count queues nothing
    send(FUNC_QUEUE, 1'b0, 16'd1);
    send(FUNC_TICK, 1'b0, 16'd0);     // train starts its low phase

    // zero limit and zero phase durations; spare address must be ignored
    apply_cfg({16'd0, 16'd1, 8'd0, 16'd0, 16'd0});
    write_reg(SPARE_REG_ADDR, 16'h0007);
    send(FUNC_EDGE, 1'b1, 16'd0);     // accepted but never counted
    send(FUNC_EDGE, 1'b0, 16'd0);     // startup not done
    send(FUNC_TICK, 1'b1, 16'd0);     // zero low phase ends at once
    send(FUNC_TICK, 1'b1, 16'd0);     // zero pause ends, queue empties

    // limit saturation, then the limit lowered under the running count
    apply_cfg({16'd0, 16'd2, 8'd3, 16'd1, 16'd1});
    repeat (5) send(FUNC_EDGE, 1'b1, 16'd0);
    drain();
    write_reg(reg_addr(REG_LIMIT), 16'd1);
    live_cfg.burst_limit = 8'd1;
    send(FUNC_EDGE, 1'b1, 16'd0);
    repeat (4) send(FUNC_TICK, 1'b1, 16'd0);  // burst of 3 credited on timeout

    // --- random phases ---
    for (p = 0; p < NUM_PHASES; p++) begin
      apply_cfg(phase_setting(p));
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      start = sent_items;
      target = (p == 2) ? 50 : 140;
      while (sent_items - start < target) begin
        if (p == 0 && !hold_done && sent_items - start > 40) begin
          // sender pauses for a full drain, then keeps offering while the
          // receiver holds off, so the block backs up into in_ready
          drain();
          rx_hold_req = 1'b1;
          while (!rx_holding) @(posedge clk);
          rx_hold_req = 1'b0;
          tx_steady = 1'b1;
          repeat (24) send(FUNC_TICK, 1'($urandom), 16'($urandom));
          tx_steady = 1'b0;
          hold_done = 1'b1;
        end
        send_chunk();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // queue saturates at the top of its range
    send(FUNC_QUEUE, 1'b1, 16'hFFFF);
    send(FUNC_QUEUE, 1'b1, 16'd7);
    repeat (3) send(FUNC_TICK, 1'b1, 16'd0);
    send(FUNC_NOP, 1'b0, 16'd0);

    drain();
    $display("Run: %0d items over %0d register settings, %0d results checked",
             sent_items, settings_applied, readouts);
    $display("Run: %0d bursts credited, long receiver hold-off and queue saturation hit",
             credited);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pbc_pkg.sv
rtl/core/pbc_regs.sv
rtl/core/pbc_core.sv
rtl/core/pulse_burst_counter_and_pulse_train.sv
verif/pbc_result_check.sv
verif/pulse_burst_counter_and_pulse_train_tb.sv
